[sv/hee_pkg.sv]
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the HTML entity escaper.
package hee_pkg;

	localparam int ROM_DEPTH = 100;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int NAME_LEN  = 6;
	localparam int RUN_LEN   = NAME_LEN + 2;
	localparam int RUN_IW    = $clog2(RUN_LEN);

	// Character codes
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;
	localparam logic [7:0] CH_CTRL_END = 8'h20;
	localparam logic [7:0] CH_HIGH_LO  = 8'h80;
	localparam logic [7:0] CH_NAMED_LO = 8'hA0;

	// ROM addresses of the four ASCII entities, after the 96 high-byte names
	localparam logic [ROM_AW-1:0] ADDR_QUOT = ROM_AW'(96);
	localparam logic [ROM_AW-1:0] ADDR_AMP  = ROM_AW'(97);
	localparam logic [ROM_AW-1:0] ADDR_LT   = ROM_AW'(98);
	localparam logic [ROM_AW-1:0] ADDR_GT   = ROM_AW'(99);

	// One ROM word: name left-justified (first letter in the top byte), zero padded
	typedef struct packed {
		logic [2:0]            len;
		logic [8*NAME_LEN-1:0] name;
	} name_entry_t;

	// Build a ROM word from a right-justified string literal.
	function automatic name_entry_t ent(input logic [8*NAME_LEN-1:0] s);
		name_entry_t e;
		e.name = s;
		e.len  = 3'd0;
		for (int i = 0; i < NAME_LEN; i++) begin
			if (e.name[8*NAME_LEN-1 -: 8] == 8'h00) begin
				e.name = e.name << 8;
			end else begin
				e.len = e.len + 3'd1;
			end
		end
		return e;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
	endfunction

endpackage

[sv/hee_name_rom.sv]
`timescale 1ns / 1ps
// Entity-name ROM with a registered read port.
module hee_name_rom (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [7:0]          rd_byte,
	output hee_pkg::name_entry_t rd_entry
);
	import hee_pkg::*;

	localparam name_entry_t NAME_ROM [ROM_DEPTH] = '{
		ent("nbsp"),   ent("iexcl"),  ent("cent"),   ent("pound"),
		ent("curren"), ent("yen"),    ent("brvbar"), ent("sect"),
		ent("uml"),    ent("copy"),   ent("ordf"),   ent("laquo"),
		ent("not"),    ent("shy"),    ent("reg"),    ent("macr"),
		ent("deg"),    ent("plusmn"), ent("sup2"),   ent("sup3"),
		ent("acute"),  ent("micro"),  ent("para"),   ent("middot"),
		ent("cedil"),  ent("sup1"),   ent("ordm"),   ent("raquo"),
		ent("frac14"), ent("frac12"), ent("frac34"), ent("iquest"),
		ent("Agrave"), ent("Aacute"), ent("Acirc"),  ent("Atilde"),
		ent("Auml"),   ent("Aring"),  ent("AElig"),  ent("Ccedil"),
		ent("Egrave"), ent("Eacute"), ent("Ecirc"),  ent("Euml"),
		ent("Igrave"), ent("Iacute"), ent("Icirc"),  ent("Iuml"),
		ent("ETH"),    ent("Ntilde"), ent("Ograve"), ent("Oacute"),
		ent("Ocirc"),  ent("Otilde"), ent("Ouml"),   ent("times"),
		ent("Oslash"), ent("Ugrave"), ent("Uacute"), ent("Ucirc"),
		ent("Uuml"),   ent("Yacute"), ent("THORN"),  ent("szlig"),
		ent("agrave"), ent("aacute"), ent("acirc"),  ent("atilde"),
		ent("auml"),   ent("aring"),  ent("aelig"),  ent("ccedil"),
		ent("egrave"), ent("eacute"), ent("ecirc"),  ent("euml"),
		ent("igrave"), ent("iacute"), ent("icirc"),  ent("iuml"),
		ent("eth"),    ent("ntilde"), ent("ograve"), ent("oacute"),
		ent("ocirc"),  ent("otilde"), ent("ouml"),   ent("divide"),
		ent("oslash"), ent("ugrave"), ent("uacute"), ent("ucirc"),
		ent("uuml"),   ent("yacute"), ent("thorn"),  ent("yuml"),
		ent("quot"),   ent("amp"),    ent("lt"),     ent("gt")
	};

	logic [7:0]        high_off;
	logic [ROM_AW-1:0] addr;

	assign high_off = rd_byte - CH_NAMED_LO;

	always_comb begin
		if (rd_byte >= CH_NAMED_LO) begin
			addr = high_off[ROM_AW-1:0];
		end else begin
			unique case (rd_byte)
				CH_QUOT: addr = ADDR_QUOT;
				CH_AMP:  addr = ADDR_AMP;
				CH_LT:   addr = ADDR_LT;
				CH_GT:   addr = ADDR_GT;
				default: addr = ADDR_QUOT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= NAME_ROM[addr];
		end
	end

endmodule

[sv/html_entity_escaper.sv]
`timescale 1ns / 1ps
// HTML entity escaper: turns each text byte into its escaped run of output beats.
//
// Each input beat carries one text byte and, in tlast, the end-of-string mark.
// The byte leaves as a run of one to eight output beats: '"', '&', '<', '>' and
// every byte from 0xA0 up become a named entity ("&amp;", "&nbsp;", "&middot;"),
// other control bytes below 0x20 and bytes 0x80 to 0x9F become "&#hh;" with
// lowercase hex, and everything else (0x7F included) passes through as itself.
// Output tlast marks the final beat of each run; tuser carries the string-end
// mark on that beat only. The first beat of a run leaves from the run register,
// which is loaded from the registered name-ROM read and the stage-1 registers;
// a byte waits in stage 1 while the run register is busy. The run register
// drains one beat a cycle while the output is ready, and once stage 1 is full
// the input is held off until the current run is done; pass-through text
// therefore flows at one byte per cycle when the output does not stall.
// Input and output are decoupled by the ROM read stage and the run register,
// so the next byte is taken while the current run is still waiting at the output.
module html_entity_escaper (
	input  logic       clk,
	input  logic       arst_n,
	// Input stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // end_of_string
	// Output stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,   // last_of_run
	output logic [0:0] m_axis_tuser    // [0] string_end_out
);
	import hee_pkg::*;

	// Expansion kinds
	localparam logic [1:0] KIND_PASS = 2'd0;
	localparam logic [1:0] KIND_HEX  = 2'd1;
	localparam logic [1:0] KIND_NAME = 2'd2;

	// Stage 1: ROM read in flight
	logic        valid_s1;
	logic        eos_s1;
	logic [7:0]  byte_s1;
	logic [1:0]  kind_s1;
	name_entry_t entry_s1;

	// Stage 2: run register, drained one beat a cycle while the output is ready
	logic              valid_s2;
	logic              eos_s2;
	logic [7:0]        run_s2 [RUN_LEN];
	logic [RUN_IW-1:0] last_s2;
	logic [RUN_IW-1:0] idx_s2;

	logic              in_beat;
	logic              out_beat;
	logic              run_done;
	logic              adv_s1;
	logic [1:0]        kind_in;
	logic [7:0]        run_nx [RUN_LEN];
	logic [RUN_IW-1:0] last_nx;

	// Classify the incoming byte
	always_comb begin
		if (s_axis_tdata >= CH_NAMED_LO || s_axis_tdata == CH_QUOT ||
		    s_axis_tdata == CH_AMP || s_axis_tdata == CH_LT || s_axis_tdata == CH_GT) begin
			kind_in = KIND_NAME;
		end else if (s_axis_tdata < CH_CTRL_END || s_axis_tdata >= CH_HIGH_LO) begin
			kind_in = KIND_HEX;
		end else begin
			kind_in = KIND_PASS;
		end
	end

	// Handshake: stage 1 moves on once the run register is empty or finishing
	assign out_beat      = m_axis_tvalid & m_axis_tready;
	assign run_done      = out_beat & (idx_s2 == last_s2);
	assign adv_s1        = valid_s1 & (~valid_s2 | run_done);
	assign s_axis_tready = ~valid_s1 | adv_s1;
	assign in_beat       = s_axis_tvalid & s_axis_tready;

	hee_name_rom u_rom (
		.clk      (clk),
		.rd_en    (in_beat),
		.rd_byte  (s_axis_tdata),
		.rd_entry (entry_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
			kind_s1 <= kind_in;
		end
	end

	// Build the run from the ROM word or the hex digits
	always_comb begin
		for (int k = 0; k < RUN_LEN; k++) begin
			run_nx[k] = 8'h00;
		end
		last_nx = '0;
		case (kind_s1)
			KIND_NAME: begin
				run_nx[0] = CH_AMP;
				for (int k = 1; k <= NAME_LEN; k++) begin
					run_nx[k] = entry_s1.name[8*(NAME_LEN-k+1)-1 -: 8];
				end
				last_nx = RUN_IW'(entry_s1.len) + RUN_IW'(1);
				run_nx[last_nx] = CH_SEMI;
			end
			KIND_HEX: begin
				run_nx[0] = CH_AMP;
				run_nx[1] = CH_HASH;
				run_nx[2] = hex_digit(byte_s1[7:4]);
				run_nx[3] = hex_digit(byte_s1[3:0]);
				run_nx[4] = CH_SEMI;
				last_nx   = RUN_IW'(4);
			end
			default: begin
				run_nx[0] = byte_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (run_done) begin
			valid_s2 <= 1'b0;
		end else if (out_beat) begin
			idx_s2 <= idx_s2 + RUN_IW'(1);
		end
	end

	// Hold the run payload until the next byte moves up
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			run_s2  <= run_nx;
			last_s2 <= last_nx;
			eos_s2  <= eos_s1;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = run_s2[idx_s2];
	assign m_axis_tlast    = (idx_s2 == last_s2);
	assign m_axis_tuser[0] = (idx_s2 == last_s2) & eos_s2;

endmodule
